>>> rtl/pcg_pkg.sv
// Shared types and constants for the PCG32 generator with bounded draw.
// No dependencies; imported by pcg_mod_unit and the top level.
`default_nettype none

package pcg_pkg;

    localparam int WORD_W  = 32;
    localparam int STATE_W = 64;
    localparam int CNT_W   = $clog2(WORD_W);

    localparam logic [STATE_W-1:0] LCG_MULT            = 64'd6364136223846793005;
    localparam logic [STATE_W-1:0] SEED_STATE_RESET    = 64'h853c49e6748fea9b;
    localparam logic [STATE_W-1:0] SEED_SEQUENCE_RESET = 64'hda3e39cb94b95bdb;

    typedef enum logic [1:0] {
        FUNC_RAW     = 2'd0,
        FUNC_BOUNDED = 2'd1,
        FUNC_KEEP    = 2'd2,
        FUNC_RESEED  = 2'd3
    } t_func;

    typedef enum logic [3:0] {
        S_SEED,
        S_IDLE,
        S_THR,
        S_ADV0,
        S_ADV1,
        S_ADV2,
        S_ADV3,
        S_CHK,
        S_KEEP,
        S_MODW,
        S_DONE
    } t_state;

    // XSH-RR output permutation of a 64-bit LCG state
    function automatic logic [WORD_W-1:0] xsh_rr(input logic [STATE_W-1:0] s);
        logic [STATE_W-1:0]  x;
        logic [WORD_W-1:0]   mixed;
        logic [4:0]          rot;
        logic [2*WORD_W-1:0] dbl;
        x     = (s >> 18) ^ s;
        mixed = x[58:27];
        rot   = s[63:59];
        dbl   = {mixed, mixed} >> rot;
        return dbl[WORD_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/pcg_mod_unit.sv
// Bit-serial restoring remainder unit: one quotient bit per cycle.
// Depends on pcg_pkg for word width constants.
`default_nettype none

module pcg_mod_unit
    import pcg_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [WORD_W-1:0] i_dividend,
    input  wire logic [WORD_W-1:0] i_divisor,
    output logic                   o_done,
    output logic [WORD_W-1:0]      o_rem
);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [WORD_W-1:0] r_rem, n_rem;
    logic [WORD_W-1:0] r_dvd, n_dvd;
    logic [WORD_W-1:0] r_dvs, n_dvs;
    logic [WORD_W:0]   trial;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dvd  = r_dvd;
        n_dvs  = r_dvs;
        trial  = {r_rem, r_dvd[WORD_W-1]} - {1'b0, r_dvs};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(WORD_W - 1);
            n_rem  = '0;
            n_dvd  = i_dividend;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            // subtract when the shifted remainder covers the divisor
            if (trial[WORD_W]) begin
                n_rem = {r_rem[WORD_W-2:0], r_dvd[WORD_W-1]};
            end else begin
                n_rem = trial[WORD_W-1:0];
            end
            n_dvd = {r_dvd[WORD_W-2:0], 1'b0};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_dvd <= n_dvd;
        r_dvs <= n_dvs;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

>>> rtl/pcg32_generator_with_bounded_draw_unit.sv
// PCG32 (XSH-RR) generator with raw draw, unbiased bounded draw, keep test and reseed.
// Depends on pcg_pkg (types, constants, output permutation) and pcg_mod_unit.
//
// One request (tuser = operation, tdata = limit) is taken at a time and yields
// exactly one result transfer. The 64-bit LCG advance runs through one shared
// 32x32 multiplier in states S_ADV0 to S_ADV3 (three partial products plus a
// final add). A bounded draw first computes the rejection threshold in the
// bit-serial remainder unit, then draws words (retrying while the word lies
// below the threshold) and takes the final remainder of the accepted word as
// the result. A zero limit on a bounded draw or keep test returns limit_error
// at once without advancing the generator. After reset the block seeds itself
// from the register reset values before the first request is accepted.
// Configuration writes change only the seed registers; the generator picks
// them up at the next reseed.
// Registers: seed_state at byte address 0x0, seed_sequence at 0x8 (64 bits).
`default_nettype none

module pcg32_generator_with_bounded_draw_unit
    import pcg_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] limit
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] func
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // [31:0] value, [32] keep, [39:33] zero
    output logic             m_axis_tuser,   // [0] limit_error
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);

    // seed registers
    logic [STATE_W-1:0] r_seed_state;
    logic [STATE_W-1:0] r_seed_seq;

    // generator state and sequencer
    t_state             r_st, n_st;
    t_func              r_func, n_func;
    logic               r_pend, n_pend;
    logic [STATE_W-1:0] r_state, n_state;
    logic [STATE_W-1:0] r_inc, n_inc;
    logic [STATE_W-1:0] r_acc, n_acc;
    logic [2*WORD_W-1:0] r_prod;
    logic [WORD_W-1:0]  r_limit, n_limit;
    logic [WORD_W-1:0]  r_thr, n_thr;
    logic [WORD_W-1:0]  r_word, n_word;
    logic [WORD_W-1:0]  r_res_value, n_res_value;
    logic               r_res_keep, n_res_keep;
    logic               r_res_err, n_res_err;

    // output register
    logic               r_out_valid, n_out_valid;
    logic [WORD_W-1:0]  r_out_value, n_out_value;
    logic               r_out_keep, n_out_keep;
    logic               r_out_err, n_out_err;

    // shared multiplier operands
    logic [WORD_W-1:0]  mul_a, mul_b;

    // remainder unit
    logic               mod_start;
    logic [WORD_W-1:0]  mod_dividend, mod_divisor;
    logic               mod_done;
    logic [WORD_W-1:0]  mod_rem;

    logic               cfg_wr;
    logic [STATE_W-1:0] seed_inc;

    pcg_mod_unit u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (mod_dividend),
        .i_divisor  (mod_divisor),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    // configuration port: write on access phase, decode on paddr[3]
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;
    assign prdata = paddr[3] ? r_seed_seq : r_seed_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_state <= SEED_STATE_RESET;
            r_seed_seq   <= SEED_SEQUENCE_RESET;
        end else if (cfg_wr) begin
            if (paddr[3]) begin
                r_seed_seq <= pwdata;
            end else begin
                r_seed_state <= pwdata;
            end
        end
    end

    assign seed_inc = {r_seed_seq[STATE_W-2:0], 1'b1};

    // sequencer: next state, datapath controls and next values
    always_comb begin
        n_st        = r_st;
        n_func      = r_func;
        n_pend      = r_pend;
        n_state     = r_state;
        n_inc       = r_inc;
        n_acc       = r_acc;
        n_limit     = r_limit;
        n_thr       = r_thr;
        n_word      = r_word;
        n_res_value = r_res_value;
        n_res_keep  = r_res_keep;
        n_res_err   = r_res_err;
        n_out_valid = r_out_valid & ~m_axis_tready;
        n_out_value = r_out_value;
        n_out_keep  = r_out_keep;
        n_out_err   = r_out_err;
        s_axis_tready = 1'b0;
        mod_start    = 1'b0;
        mod_dividend = r_word;
        mod_divisor  = r_limit;
        mul_a        = r_state[WORD_W-1:0];
        mul_b        = LCG_MULT[WORD_W-1:0];

        case (r_st)
            S_SEED: begin
                // state = 0 -> first advance gives inc; then add seed_state
                n_inc   = seed_inc;
                n_state = seed_inc + r_seed_state;
                n_st    = S_ADV0;
            end
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_func      = t_func'(s_axis_tuser);
                    n_limit     = s_axis_tdata;
                    n_pend      = 1'b1;
                    n_res_value = '0;
                    n_res_keep  = 1'b0;
                    n_res_err   = 1'b0;
                    case (t_func'(s_axis_tuser))
                        FUNC_RAW: begin
                            n_st = S_ADV0;
                        end
                        FUNC_BOUNDED: begin
                            if (s_axis_tdata == '0) begin
                                n_res_err = 1'b1;
                                n_st      = S_DONE;
                            end else begin
                                // threshold = (2^32 - limit) mod limit
                                mod_start    = 1'b1;
                                mod_dividend = '0 - s_axis_tdata;
                                mod_divisor  = s_axis_tdata;
                                n_st         = S_THR;
                            end
                        end
                        FUNC_KEEP: begin
                            if (s_axis_tdata == '0) begin
                                n_res_err = 1'b1;
                                n_st      = S_DONE;
                            end else begin
                                n_st = S_ADV0;
                            end
                        end
                        default: begin
                            n_st = S_SEED;
                        end
                    endcase
                end
            end
            S_THR: begin
                if (mod_done) begin
                    n_thr = mod_rem;
                    n_st  = S_ADV0;
                end
            end
            S_ADV0: begin
                // capture the output word of the old state, start low product
                n_word = xsh_rr(r_state);
                n_st   = S_ADV1;
            end
            S_ADV1: begin
                mul_a = r_state[WORD_W-1:0];
                mul_b = LCG_MULT[STATE_W-1:WORD_W];
                n_acc = r_prod + r_inc;
                n_st  = S_ADV2;
            end
            S_ADV2: begin
                mul_a = r_state[STATE_W-1:WORD_W];
                mul_b = LCG_MULT[WORD_W-1:0];
                n_acc = r_acc + {r_prod[WORD_W-1:0], {WORD_W{1'b0}}};
                n_st  = S_ADV3;
            end
            S_ADV3: begin
                n_state = r_acc + {r_prod[WORD_W-1:0], {WORD_W{1'b0}}};
                n_st    = S_CHK;
            end
            S_CHK: begin
                mul_a = r_word;
                mul_b = r_limit;
                case (r_func)
                    FUNC_RAW: begin
                        n_res_value = r_word;
                        n_st        = S_DONE;
                    end
                    FUNC_BOUNDED: begin
                        if (r_word < r_thr) begin
                            // reject and draw again
                            n_st = S_ADV0;
                        end else begin
                            mod_start = 1'b1;
                            n_st      = S_MODW;
                        end
                    end
                    FUNC_KEEP: begin
                        n_st = S_KEEP;
                    end
                    default: begin
                        // reseed: report only when a request asked for it
                        n_st = r_pend ? S_DONE : S_IDLE;
                    end
                endcase
            end
            S_KEEP: begin
                n_res_keep = (r_prod[2*WORD_W-1:WORD_W] == '0);
                n_st       = S_DONE;
            end
            S_MODW: begin
                if (mod_done) begin
                    n_res_value = mod_rem;
                    n_st        = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_value = r_res_value;
                    n_out_keep  = r_res_keep;
                    n_out_err   = r_res_err;
                    n_pend      = 1'b0;
                    n_st        = S_IDLE;
                end
            end
            default: begin
                n_st = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= S_SEED;
            r_func      <= FUNC_RESEED;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_st        <= n_st;
            r_func      <= n_func;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
        r_state     <= n_state;
        r_inc       <= n_inc;
        r_acc       <= n_acc;
        r_prod      <= {{WORD_W{1'b0}}, mul_a} * {{WORD_W{1'b0}}, mul_b};
        r_limit     <= n_limit;
        r_thr       <= n_thr;
        r_word      <= n_word;
        r_res_value <= n_res_value;
        r_res_keep  <= n_res_keep;
        r_res_err   <= n_res_err;
        r_out_value <= n_out_value;
        r_out_keep  <= n_out_keep;
        r_out_err   <= n_out_err;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_keep, r_out_value};
    assign m_axis_tuser  = r_out_err;

endmodule

`default_nettype wire
